// ===== sv/sampled_adjacency_search_top_macros.svh =====
// assertion macros for the sampled adjacency search block
// used by the port checker; no other dependencies
`ifndef SAMPLED_ADJACENCY_SEARCH_TOP_MACROS_SVH
`define SAMPLED_ADJACENCY_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define SAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sas port check failed");

// next-cycle implication, disabled while rst_n is low
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sas port check failed");

`endif

// ===== sv/sas_pkg.sv =====
// shared types and codes for the sampled adjacency search block
// no dependencies; compiled first
package sas_pkg;

    localparam int FUNC_W     = 2;
    localparam int VERTEX_W   = 10;
    localparam int NEIGHBOR_W = 32;
    localparam int POSITION_W = 15;
    localparam int STATUS_W   = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLOSE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [VERTEX_W-1:0]   vertex;
        logic [NEIGHBOR_W-1:0] neighbor;
    } t_in_item;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic                  found;
        logic [STATUS_W-1:0]   status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic do_append;
        logic do_close;
        logic do_clear;
        logic set_full;
        logic set_nl;
        logic list_rd;
        logic list_lat;
        logic head_rd;
        logic set_tail;
        logic set_bs;
        logic mid_rd;
        logic mid_upd;
        logic range_set;
        logic scan_rd;
        logic found_set;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              app_full;
        logic              vtx_full;
        logic              vtx_bad;
        logic              len_zero;
        logic              le;
        logic              b_gap;
        logic              more;
        logic              match;
        logic              out_free;
    } t_dp_stat;

endpackage

// ===== sv/sas_if.sv =====
// valid/ready channel interfaces for request and response transactions
// depends on sas_pkg
interface sas_in_if;
    import sas_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sas_out_if;
    import sas_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sas_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sas_ctrl.sv =====
// sequencing state machine: accept, execute, block search, scan, deliver
// depends on sas_pkg
module sas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sas_pkg::t_dp_stat i_stat,
    output sas_pkg::t_dp_cmd  o_cmd
);
    import sas_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_LIST = 4'd2;
    localparam logic [3:0] S_HREQ = 4'd3;
    localparam logic [3:0] S_HCMP = 4'd4;
    localparam logic [3:0] S_BCHK = 4'd5;
    localparam logic [3:0] S_BCMP = 4'd6;
    localparam logic [3:0] S_SCAN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_pend;   // scan read in flight
    logic       n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.func)
                    FN_APPEND: begin
                        if (i_stat.app_full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.do_append = 1'b1;
                        end
                    end
                    FN_CLOSE: begin
                        if (i_stat.vtx_full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.do_close = 1'b1;
                        end
                    end
                    FN_QUERY: begin
                        if (i_stat.vtx_bad) begin
                            o_cmd.set_nl = 1'b1;
                        end else begin
                            o_cmd.list_rd = 1'b1;
                            n_state       = S_LIST;
                        end
                    end
                    FN_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                    end
                    default: begin
                        o_cmd.do_clear = 1'b1;
                    end
                endcase
            end
            S_LIST: begin
                o_cmd.list_lat = 1'b1;
                n_state = i_stat.len_zero ? S_DONE : S_HREQ;
            end
            S_HREQ: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HCMP;
            end
            S_HCMP: begin
                if (i_stat.le) begin
                    o_cmd.set_tail = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.set_bs = 1'b1;
                    n_state      = S_BCHK;
                end
            end
            S_BCHK: begin
                if (i_stat.b_gap) begin
                    o_cmd.mid_rd = 1'b1;
                    n_state      = S_BCMP;
                end else begin
                    o_cmd.range_set = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_BCMP: begin
                o_cmd.mid_upd = 1'b1;
                n_state       = S_BCHK;
            end
            S_SCAN: begin
                if (r_pend && i_stat.match) begin
                    o_cmd.found_set = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.more) begin
                    o_cmd.scan_rd = 1'b1;
                    n_pend        = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sas_dp.sv =====
// datapath: list counters, neighbor store, list table, search registers, output register
// depends on sas_pkg and sas_ram
module sas_dp #(
    parameter int MAX_VERTICES   = 1024,
    parameter int MAX_ENTRIES    = 16384,
    parameter int SAMPLE_SPACING = 32,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sas_pkg::t_dp_cmd   i_cmd,
    output sas_pkg::t_dp_stat  o_stat,
    input  sas_pkg::t_in_item  i_in_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output sas_pkg::t_out_item o_out_data
);
    import sas_pkg::*;

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int AW  = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int VAW = MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1;
    localparam int SW  = SAMPLE_SPACING > 1 ? $clog2(SAMPLE_SPACING) : 1;
    localparam int LW  = 3 * CW;
    localparam int KW  = VALUE_WIDTH > NEIGHBOR_W ? VALUE_WIDTH : NEIGHBOR_W;
    localparam int XW  = VCW > VERTEX_W ? VCW : VERTEX_W;
    localparam int PW  = CW > POSITION_W ? CW : POSITION_W;

    // operation registers
    logic [FUNC_W-1:0]      r_func;
    logic [VERTEX_W-1:0]    r_vertex;
    logic [VALUE_WIDTH-1:0] r_key;

    // load-side counters
    logic [VCW-1:0] r_vloaded;
    logic [CW-1:0]  r_fill;
    logic [CW-1:0]  r_open_len;
    logic [SW-1:0]  r_open_mod;
    logic [CW-1:0]  r_open_blk;
    logic [CW-1:0]  r_last_blk;

    // search registers
    logic [CW-1:0] r_base;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_lblk;
    logic [CW-1:0] r_b0;
    logic [CW-1:0] r_b1;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_hi;

    // result and output registers
    logic [CW-1:0]       r_res_pos;
    logic                r_res_found;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [VALUE_WIDTH-1:0] store_q;
    logic [LW-1:0]          list_q;
    logic [LW-1:0]          list_wd;
    logic [CW-1:0]          mid_n;
    logic [CW-1:0]          blk_sel;
    logic [CW-1:0]          blk_off;
    logic [CW-1:0]          rd_off;
    logic                   store_rd;

    assign mid_n   = CW'(({1'b0, r_b0} + {1'b0, r_b1}) >> 1);
    assign blk_sel = i_cmd.mid_rd ? mid_n : r_lblk;
    assign blk_off = CW'(blk_sel * SAMPLE_SPACING);
    assign rd_off  = i_cmd.scan_rd ? r_i : blk_off;
    assign store_rd = i_cmd.head_rd | i_cmd.mid_rd | i_cmd.scan_rd;
    assign list_wd = {CW'(r_fill - r_open_len), r_open_len, r_last_blk};

    sas_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (i_cmd.do_append),
        .i_wr_addr (AW'(r_fill)),
        .i_wr_data (r_key),
        .i_rd_en   (store_rd),
        .i_rd_addr (AW'(r_base + rd_off)),
        .o_rd_data (store_q)
    );

    sas_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_VERTICES)
    ) u_list (
        .i_clk     (i_clk),
        .i_we      (i_cmd.do_close),
        .i_wr_addr (VAW'(r_vloaded)),
        .i_wr_data (list_wd),
        .i_rd_en   (i_cmd.list_rd),
        .i_rd_addr (VAW'(XW'(r_vertex))),
        .o_rd_data (list_q)
    );

    always_comb begin
        o_stat.func     = r_func;
        o_stat.vtx_full = (r_vloaded == VCW'(MAX_VERTICES));
        o_stat.app_full = (r_fill == CW'(MAX_ENTRIES)) || o_stat.vtx_full;
        o_stat.vtx_bad  = (XW'(r_vertex) >= XW'(r_vloaded));
        o_stat.len_zero = (list_q[2*CW-1 -: CW] == '0);
        o_stat.le       = (store_q <= r_key);
        o_stat.b_gap    = (CW'(r_b1 - r_b0) > CW'(1));
        o_stat.more     = (r_i < r_hi);
        o_stat.match    = (store_q == r_key);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vloaded   <= '0;
            r_fill      <= '0;
            r_open_len  <= '0;
            r_open_mod  <= '0;
            r_open_blk  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_append) begin
                r_fill     <= r_fill + CW'(1);
                r_open_len <= r_open_len + CW'(1);
                if (r_open_mod == SW'(SAMPLE_SPACING - 1)) begin
                    r_open_mod <= '0;
                    r_open_blk <= r_open_blk + CW'(1);
                end else begin
                    r_open_mod <= r_open_mod + SW'(1);
                end
            end
            if (i_cmd.do_close) begin
                r_vloaded  <= r_vloaded + VCW'(1);
                r_open_len <= '0;
                r_open_mod <= '0;
                r_open_blk <= '0;
            end
            if (i_cmd.do_clear) begin
                r_vloaded  <= '0;
                r_fill     <= '0;
                r_open_len <= '0;
                r_open_mod <= '0;
                r_open_blk <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func       <= i_in_data.func;
            r_vertex     <= i_in_data.vertex;
            r_key        <= VALUE_WIDTH'(KW'(i_in_data.neighbor));
            r_res_pos    <= '0;
            r_res_found  <= 1'b0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.do_append) begin
            r_last_blk <= r_open_blk;
        end
        if (i_cmd.set_full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.set_nl) begin
            r_res_status <= ST_NOT_LOADED;
        end
        if (i_cmd.list_lat) begin
            r_base <= list_q[LW-1 -: CW];
            r_len  <= list_q[2*CW-1 -: CW];
            r_lblk <= list_q[CW-1:0];
        end
        if (i_cmd.set_tail) begin
            r_i  <= blk_off;
            r_hi <= r_len;
        end
        if (i_cmd.set_bs) begin
            r_b0 <= '0;
            r_b1 <= r_lblk;
        end
        if (i_cmd.mid_rd) begin
            r_mid <= mid_n;
        end
        if (i_cmd.mid_upd) begin
            if (o_stat.le) begin
                r_b0 <= r_mid;
            end else begin
                r_b1 <= r_mid;
            end
        end
        if (i_cmd.range_set) begin
            r_i  <= CW'(r_b0 * SAMPLE_SPACING);
            r_hi <= CW'(r_b1 * SAMPLE_SPACING);
        end
        if (i_cmd.scan_rd) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.found_set) begin
            r_res_pos   <= r_i;
            r_res_found <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.position <= POSITION_W'(PW'(r_res_pos));
            r_out.found    <= r_res_found;
            r_out.status   <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/sampled_adjacency_search_top.sv =====
// sampled adjacency search: holds sorted neighbor lists per vertex and answers
// adjacency queries; depends on sas_pkg, sas_if, sas_ctrl, sas_dp, sas_ram
//
// - i_req carries one transaction per operation: func, vertex, neighbor.
//   append adds a value to the open list, close turns the open list into the
//   next vertex's list, query looks up (vertex, neighbor), clear empties all
// - o_rsp returns exactly one transaction per request, in order: position
//   (1-based, 0 if absent), found, status (ok, full, vertex not loaded)
// - one request is worked on at a time; append, close, clear and a query on a
//   vertex that is not loaded go from execute to done and the output register,
//   a query on an empty list reads the list table on the way
// - any other query reads the last block head and scans the tail when the key is
//   at or past it, else first halves over block heads; it scans at most the
//   spacing in entries and stops at the first match
// - the controller returns to idle as a result is registered and takes the next
//   request even while that result still waits for o_rsp.ready; a stalled
//   receiver holds the output register, and a finished result behind it waits
//   in the controller until the register frees
// - reset clears the counters and the output valid at once; store contents stay
module sampled_adjacency_search_top #(
    parameter int MAX_VERTICES   = 1024,
    parameter int MAX_ENTRIES    = 16384,
    parameter int SAMPLE_SPACING = 32,
    parameter int VALUE_WIDTH    = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    sas_in_if.sink    i_req,
    sas_out_if.source o_rsp
);
    import sas_pkg::*;

    t_dp_cmd   cmd;    // controller commands
    t_dp_stat  stat;   // datapath flags back to the controller
    t_out_item rsp_data;
    logic      rsp_valid;
    logic      req_ready;

    // state machine: owns the request handshake and the search sequence
    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (req_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: counters, memories, search registers and output register
    sas_dp #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_ENTRIES    (MAX_ENTRIES),
        .SAMPLE_SPACING (SAMPLE_SPACING),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_req.data),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (rsp_valid),
        .o_out_data  (rsp_data)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp_data;

endmodule

// ===== sv/sas_checker.sv =====
// port-level checks on the response channel of the sampled adjacency search
// depends on sas_pkg and the assertion macro header; bound to the top level
`include "sampled_adjacency_search_top_macros.svh"

module sas_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [sas_pkg::POSITION_W-1:0] i_out_position,
    input logic                           i_out_found,
    input logic [sas_pkg::STATUS_W-1:0]   i_out_status
);
    import sas_pkg::*;

    // a stalled response keeps its contents
    `SAS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_position) && $stable(i_out_found) && $stable(i_out_status))

    // found and a nonzero position go together
    `SAS_ASSERT_NOW(a_found_pos, i_clk, i_rst_n, i_out_valid, i_out_found == (i_out_position != '0))

    // a hit is always a clean query
    `SAS_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, i_out_valid && i_out_found, i_out_status == ST_OK)

    // error results carry no position
    `SAS_ASSERT_NOW(a_err_empty, i_clk, i_rst_n, i_out_valid && (i_out_status != ST_OK), (i_out_position == '0) && !i_out_found)

    // no response straight out of reset
    `SAS_ASSERT_NEXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !i_out_valid)

endmodule

bind sampled_adjacency_search_top sas_checker u_sas_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_position (o_rsp.data.position),
    .i_out_found    (o_rsp.data.found),
    .i_out_status   (o_rsp.data.status)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for sampled_adjacency_search_top: directed table, then random list builds and queries
// depends on sas_pkg, sas_if and the block's rtl; responses are checked against a local predictor
module tb_top;
    import sas_pkg::*;

    // block sizes, kept equal to the instance parameters below
    localparam int MAX_VERTICES   = 1024;
    localparam int MAX_ENTRIES    = 16384;
    localparam int SAMPLE_SPACING = 32;

    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 8;
    // a run is roughly 2k transactions
    localparam int CYCLE_LIMIT  = 2_000_000;
    // idle time at the end, after every response is back
    localparam int TAIL_CYCLES  = 200;

    localparam t_out_item RSP_OK   = '{position: '0, found: 1'b0, status: ST_OK};
    localparam t_out_item RSP_FULL = '{position: '0, found: 1'b0, status: ST_FULL};
    localparam t_out_item RSP_NL   = '{position: '0, found: 1'b0, status: ST_NOT_LOADED};

    typedef struct {
        logic [FUNC_W-1:0]     func;
        logic [VERTEX_W-1:0]   vertex;
        logic [NEIGHBOR_W-1:0] neighbor;  // first value; later repeats add step
        int                    step;
        int                    rep;
        bit                    typed;     // use rsp below instead of the predictor
        t_out_item             rsp;
    } t_dir_row;

    localparam int N_DIR = 26;

    logic i_clk;
    logic i_rst_n;

    sas_in_if  req_if ();
    sas_out_if rsp_if ();

    sampled_adjacency_search_top #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_ENTRIES    (MAX_ENTRIES),
        .SAMPLE_SPACING (SAMPLE_SPACING),
        .VALUE_WIDTH    (NEIGHBOR_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor copy of the block state
    logic [NEIGHBOR_W-1:0] store_m [MAX_ENTRIES];
    int unsigned           lstart_m [MAX_VERTICES];
    int unsigned           llen_m [MAX_VERTICES];
    int unsigned           loaded_m;
    int unsigned           fill_m;
    int unsigned           open_m;

    t_out_item pending_rsp [$];
    t_out_item want;
    t_dir_row  dir_table [N_DIR];

    int  err_count;
    int  cycle_count;
    int  rnd_items;
    bit  idle_on;
    bit  stall_on;

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned exp_val);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, field, got,
                 exp_val);
        err_count++;
    endtask

    // 1-based position of the first match in the scanned range, 0 if absent; same block search as the hardware
    function automatic int unsigned search_position(input int unsigned base,
                                                    input int unsigned len,
                                                    input logic [NEIGHBOR_W-1:0] key);
        int unsigned last_blk, lo, hi, b0, b1, mid;
        if (len == 0) return 0;
        last_blk = (len - 1) / SAMPLE_SPACING;
        if (store_m[base + last_blk * SAMPLE_SPACING] <= key) begin
            // key at or past the last block head: scan just the tail
            lo = last_blk * SAMPLE_SPACING;
            hi = len;
        end else begin
            // binary search over block heads down to one block range
            b0 = 0;
            b1 = last_blk;
            while (b1 - b0 > 1) begin
                mid = (b0 + b1) / 2;
                if (key < store_m[base + mid * SAMPLE_SPACING]) b1 = mid;
                else b0 = mid;
            end
            lo = b0 * SAMPLE_SPACING;
            hi = b1 * SAMPLE_SPACING;
        end
        for (int unsigned i = lo; i < hi; i++) begin
            if (store_m[base + i] == key) return i + 1;
        end
        return 0;
    endfunction

    // applies one request to the predictor state and returns its response
    function automatic t_out_item predict_adjacency(input t_in_item item);
        t_out_item   r;
        int unsigned pos;
        r = RSP_OK;
        case (item.func)
            FN_APPEND: begin
                if (fill_m >= MAX_ENTRIES || loaded_m >= MAX_VERTICES) begin
                    r.status = ST_FULL;
                end else begin
                    store_m[fill_m] = item.neighbor;
                    fill_m++;
                    open_m++;
                end
            end
            FN_CLOSE: begin
                if (loaded_m >= MAX_VERTICES) begin
                    r.status = ST_FULL;
                end else begin
                    lstart_m[loaded_m] = fill_m - open_m;
                    llen_m[loaded_m]   = open_m;
                    loaded_m++;
                    open_m = 0;
                end
            end
            FN_QUERY: begin
                if (item.vertex >= loaded_m) begin
                    r.status = ST_NOT_LOADED;
                end else begin
                    pos = search_position(lstart_m[item.vertex], llen_m[item.vertex],
                                          item.neighbor);
                    r.position = pos[POSITION_W-1:0];
                    r.found    = (pos != 0);
                end
            end
            FN_CLEAR: begin
                loaded_m = 0;
                fill_m   = 0;
                open_m   = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // drives one request transaction, with a random idle gap in front of it
    task automatic send_req(input t_in_item item, input bit typed, input t_out_item typed_rsp);
        int        gap;
        t_out_item model_rsp;
        gap = 0;
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // accepted at this edge
        model_rsp = predict_adjacency(item);
        pending_rsp.push_back(typed ? typed_rsp : model_rsp);
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [VERTEX_W-1:0] vertex,
                           input logic [NEIGHBOR_W-1:0] neighbor);
        t_in_item item;
        item.func     = func;
        item.vertex   = vertex;
        item.neighbor = neighbor;
        send_req(item, 1'b0, RSP_OK);
        rnd_items++;
    endtask

    // sender holds off until every response is back
    task automatic drain_rsp();
        if (pending_rsp.size() != 0) begin
            req_if.valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge i_clk);
        end
    endtask

    // query on a loaded vertex: mostly hits, some near misses, some random keys
    task automatic random_query();
        int unsigned           v, len, sel;
        logic [NEIGHBOR_W-1:0] key;
        if (loaded_m == 0 || $urandom_range(7) == 0) begin
            send_op(FN_QUERY, VERTEX_W'($urandom_range(MAX_VERTICES - 1)), $urandom);
        end else begin
            v   = $urandom_range(loaded_m - 1);
            len = llen_m[v];
            sel = $urandom_range(9);
            key = $urandom;
            if (len > 0 && sel < 8) begin
                key = store_m[lstart_m[v] + $urandom_range(len - 1)];
                if (sel == 6) key = key + 1;
                if (sel == 7) key = key - 1;
            end
            send_op(FN_QUERY, VERTEX_W'(v), key);
        end
    endtask

    // one sorted list with random gaps, the odd out-of-order value and stray queries
    task automatic build_list();
        int unsigned           len, gmax;
        logic [NEIGHBOR_W-1:0] val;
        case ($urandom_range(9))
            0: len = $urandom_range(65, 260);
            1: len = SAMPLE_SPACING * $urandom_range(1, 2) + $urandom_range(2) - 1;
            default: len = $urandom_range(40);
        endcase
        case ($urandom_range(3))
            0: gmax = 0;
            1: gmax = 4;
            2: gmax = 1000;
            default: gmax = 1 << 24;
        endcase
        val = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(39) == 0) begin
                send_op(FN_APPEND, VERTEX_W'($urandom), $urandom);
            end else begin
                send_op(FN_APPEND, VERTEX_W'($urandom), val);
                val = val + $urandom_range(gmax);
            end
            if ($urandom_range(19) == 0) random_query();
        end
        send_op(FN_CLOSE, VERTEX_W'($urandom), $urandom);
    endtask

    // stray append, close or query with random fields
    function automatic logic [FUNC_W-1:0] FN_FUNC_NOISE();
        case ($urandom_range(2))
            0: return FN_APPEND;
            1: return FN_CLOSE;
            default: return FN_QUERY;
        endcase
    endfunction

    // response checker and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response, position", rsp_if.data.position, 0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (rsp_if.data.position !== want.position)
                        report_mismatch("position", rsp_if.data.position, want.position);
                    if (rsp_if.data.found !== want.found)
                        report_mismatch("found", rsp_if.data.found, want.found);
                    if (rsp_if.data.status !== want.status)
                        report_mismatch("status", rsp_if.data.status, want.status);
                end
            end
            rsp_if.ready <= !(stall_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        t_in_item item;
        int       nv, nq;

        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        err_count    = 0;
        cycle_count  = 0;
        rnd_items    = 0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        loaded_m     = 0;
        fill_m       = 0;
        open_m       = 0;

        dir_table = '{
            // before any list: vertex not loaded
            '{FN_QUERY,  10'd0,    32'd0,          0,    1,     1'b1, RSP_NL},
            // vertex 0 gets an empty list
            '{FN_CLOSE,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_QUERY,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_QUERY,  10'd1023, 32'hFFFF_FFFF,  0,    1,     1'b1, RSP_NL},
            // vertex 1: 0, 1000 .. 68000, max value; three blocks
            '{FN_APPEND, 10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_APPEND, 10'd0,    32'd1000,       1000, 68,    1'b0, RSP_OK},
            '{FN_APPEND, 10'd0,    32'hFFFF_FFFF,  0,    1,     1'b1, RSP_OK},
            '{FN_CLOSE,  10'd1,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_QUERY,  10'd1,    32'd0,          0,    1,     1'b1, '{15'd1, 1'b1, ST_OK}},
            '{FN_QUERY,  10'd1,    32'hFFFF_FFFF,  0,    1,     1'b1, '{15'd70, 1'b1, ST_OK}},
            '{FN_QUERY,  10'd1,    32'd5000,       0,    1,     1'b0, RSP_OK},
            '{FN_QUERY,  10'd1,    32'd33001,      0,    1,     1'b0, RSP_OK},
            '{FN_QUERY,  10'd1,    32'd64000,      0,    1,     1'b0, RSP_OK},
            '{FN_QUERY,  10'd2,    32'd0,          0,    1,     1'b1, RSP_NL},
            // vertex 2: descending list, searched as if sorted
            '{FN_APPEND, 10'd0,    32'd100,        -1,   40,    1'b0, RSP_OK},
            '{FN_CLOSE,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_QUERY,  10'd2,    32'd61,         0,    1,     1'b0, RSP_OK},
            '{FN_QUERY,  10'd2,    32'd100,        0,    1,     1'b0, RSP_OK},
            // clear, then nothing is loaded
            '{FN_CLEAR,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_QUERY,  10'd0,    32'd0,          0,    1,     1'b1, RSP_NL},
            // clear, then fill the vertex table with empty lists
            '{FN_CLEAR,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_CLOSE,  10'd0,    32'd0,          0,    MAX_VERTICES, 1'b1, RSP_OK},
            '{FN_CLOSE,  10'd0,    32'd0,          0,    1,     1'b1, RSP_FULL},
            '{FN_APPEND, 10'd0,    32'd5,          0,    1,     1'b1, RSP_FULL},
            '{FN_QUERY,  10'd1023, 32'd0,          0,    1,     1'b1, RSP_OK},
            '{FN_CLEAR,  10'd0,    32'd0,          0,    1,     1'b1, RSP_OK}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_DIR; r++) begin
            // the vertex-table fill runs with no idling on either side
            idle_on  = (dir_table[r].rep < MAX_VERTICES);
            stall_on = idle_on;
            for (int k = 0; k < dir_table[r].rep; k++) begin
                item.func     = dir_table[r].func;
                item.vertex   = dir_table[r].vertex;
                item.neighbor = dir_table[r].neighbor + NEIGHBOR_W'(k * dir_table[r].step);
                send_req(item, dir_table[r].typed, dir_table[r].rsp);
            end
        end
        drain_rsp();

        // random phases: a few lists, then queries against everything loaded
        idle_on  = 1'b1;
        stall_on = 1'b1;
        while (rnd_items < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0 || fill_m > 12000 || loaded_m > 1000)
                send_op(FN_CLEAR, VERTEX_W'($urandom), $urandom);
            nv = $urandom_range(1, 6);
            for (int i = 0; i < nv; i++) build_list();
            nq = $urandom_range(4, 16);
            for (int i = 0; i < nq; i++) begin
                if ($urandom_range(11) == 0)
                    send_op(FN_FUNC_NOISE(), VERTEX_W'($urandom), $urandom);
                else
                    random_query();
            end
            if ($urandom_range(2) == 0) drain_rsp();
        end

        drain_rsp();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
